// ----- hw/rtl/frpb_pkg.sv -----
// Shared types and constants of the framed packet ring buffer.
package frpb_pkg;

    localparam int DEF_RING_DEPTH = 4096;
    localparam int SUM_W          = 34;
    localparam int CNT_W          = 6;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 48;

    localparam logic [7:0]            SYNC_BYTE      = 8'h0F;
    localparam logic [CFG_IDX_W-1:0]  CFG_RING_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_CSUM_EN    = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RING_SIZE_RST  = 13'd4096;

    typedef enum logic [2:0] {
        OP_WR_START  = 3'd0,
        OP_WR_BYTE   = 3'd1,
        OP_WR_COMMIT = 3'd2,
        OP_RD_START  = 3'd3,
        OP_RD_BYTE   = 3'd4,
        OP_RD_FINISH = 3'd5,
        OP_RD_ABORT  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_BAD_SYNC   = 3'd2,
        ST_CSUM_ERR   = 3'd3,
        ST_INCOMPLETE = 3'd4,
        ST_NOT_OPEN   = 3'd5,
        ST_EXHAUSTED  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CALC,
        S_ACT,
        S_RDW,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        A_WR,
        A_RD,
        A_PTR
    } t_act;

    typedef struct packed {
        t_act             act;
        logic             use_rp;
        logic [SUM_W-1:0] off;
        logic [7:0]       wdata;
        logic             last;
        logic [2:0]       nk;
    } t_step;

endpackage

// ----- hw/rtl/framed_packet_ring_buffer_unit.sv -----
// Framed packet ring buffer: sequencer, address remainder unit and ring RAM.
// Ring addresses are (base + offset) mod size from a bit-serial remainder unit; a ring step
// runs S_LOAD, S_CALC and S_ACT, plus S_RDW when it reads. An operation rejected up front
// goes straight to S_FIN; a commit or finish with checksum off skips the checksum step.
// One operation at a time; the next transfer is taken in the cycle after the result is loaded.
// Synchronous active-low reset clears pointers, counters and flags; ring contents are kept.
module framed_packet_ring_buffer_unit #(
    parameter int RING_DEPTH = frpb_pkg::DEF_RING_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [2:0] operation, [10:3] data_in, [11] newest
    input  logic [frpb_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [2:0] status, [10:3] data_out, [42:11] length_out
    output logic [frpb_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [frpb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [frpb_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import frpb_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int NW = $clog2(RING_DEPTH + 1);
    localparam int CW = (NW > CFG_DATA_W) ? NW : CFG_DATA_W;

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_ring_size;
    logic                  r_csum_en;

    logic [AW-1:0] r_wp, r_np, r_rp;
    logic          r_writing, r_reading;
    logic [31:0]   r_wc, r_rt, r_rc;
    logic [7:0]    r_ws, r_rs;

    t_op        r_op;
    logic [7:0] r_din;
    logic [2:0] r_k;

    logic [NW-1:0]    r_rem;
    logic [SUM_W-1:0] r_dvd;
    logic [CNT_W-1:0] r_cnt;

    t_status     r_status;
    logic [7:0]  r_dout;
    logic [31:0] r_lout;
    logic        r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    logic [CW-1:0] size_ext;
    logic [NW-1:0] size_n;
    logic [NW:0]   rem_try;
    logic [NW:0]   rem_sub;
    t_step         step;
    logic          in_xfer;
    logic          out_load;
    logic          mem_we;
    logic [7:0]    mem_rdata;
    logic [AW-1:0] mem_addr;
    t_op           in_op;

    assign in_op    = t_op'(i_s_tdata[2:0]);
    assign in_xfer  = i_s_tvalid && o_s_tready;
    assign out_load = (r_state == S_FIN) && (!r_m_valid || i_m_tready);

    always_comb begin
        size_ext = CW'(r_ring_size);
        if (size_ext < CW'(16)) begin
            size_n = NW'(16);
        end else if (size_ext > CW'(RING_DEPTH)) begin
            size_n = NW'(RING_DEPTH);
        end else begin
            size_n = NW'(size_ext);
        end
    end

    assign rem_try = {r_rem, r_dvd[SUM_W-1]};
    assign rem_sub = rem_try - {1'b0, size_n};

    // step decode: offset, base, action and successor per operation
    always_comb begin
        step.act    = A_PTR;
        step.use_rp = 1'b1;
        step.off    = '0;
        step.wdata  = '0;
        step.last   = 1'b1;
        step.nk     = '0;
        case (r_op)
            OP_WR_START: begin
                step.act    = A_WR;
                step.use_rp = 1'b0;
                step.wdata  = SYNC_BYTE;
            end
            OP_WR_BYTE: begin
                step.act    = A_WR;
                step.use_rp = 1'b0;
                step.off    = SUM_W'(r_wc) + SUM_W'(5);
                step.wdata  = r_din;
            end
            OP_WR_COMMIT: begin
                step.use_rp = 1'b0;
                case (r_k)
                    3'd0, 3'd1, 3'd2, 3'd3: begin
                        step.act   = A_WR;
                        step.off   = SUM_W'(r_k) + SUM_W'(1);
                        step.wdata = r_wc[8*r_k[1:0] +: 8];
                        step.last  = 1'b0;
                        step.nk    = (r_k == 3'd3) ? (r_csum_en ? 3'd4 : 3'd5) : r_k + 3'd1;
                    end
                    3'd4: begin
                        step.act   = A_WR;
                        step.off   = SUM_W'(r_wc) + SUM_W'(5);
                        step.wdata = r_ws;
                        step.last  = 1'b0;
                        step.nk    = 3'd5;
                    end
                    default: begin
                        step.act = A_PTR;
                        step.off = SUM_W'(r_wc) + SUM_W'(6);
                    end
                endcase
            end
            OP_RD_START: begin
                step.act  = A_RD;
                step.off  = SUM_W'(r_k);
                step.last = (r_k == 3'd4);
                step.nk   = r_k + 3'd1;
            end
            OP_RD_BYTE: begin
                step.act = A_RD;
                step.off = SUM_W'(r_rc) + SUM_W'(5);
            end
            OP_RD_FINISH: begin
                if (r_k == 3'd0) begin
                    step.act  = A_RD;
                    step.off  = SUM_W'(r_rt) + SUM_W'(5);
                    step.last = 1'b0;
                    step.nk   = 3'd1;
                end else begin
                    step.off = SUM_W'(r_rt) + SUM_W'(6);
                end
            end
            default: begin
                step.off = SUM_W'(r_rt) + SUM_W'(6);
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (in_op)
                        OP_WR_START: n_state = S_LOAD;
                        OP_WR_BYTE, OP_WR_COMMIT: begin
                            n_state = r_writing ? S_LOAD : S_FIN;
                        end
                        OP_RD_START: n_state = (r_wp == r_rp) ? S_FIN : S_LOAD;
                        OP_RD_BYTE: begin
                            n_state = (r_reading && r_rc != r_rt) ? S_LOAD : S_FIN;
                        end
                        OP_RD_FINISH: begin
                            n_state = (r_reading && r_rc == r_rt) ? S_LOAD : S_FIN;
                        end
                        OP_RD_ABORT: n_state = r_reading ? S_LOAD : S_FIN;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_LOAD: n_state = S_CALC;
            S_CALC: n_state = (r_cnt == CNT_W'(SUM_W - 1)) ? S_ACT : S_CALC;
            S_ACT: begin
                if (step.act == A_RD) begin
                    n_state = S_RDW;
                end else begin
                    n_state = step.last ? S_FIN : S_LOAD;
                end
            end
            S_RDW: begin
                if (r_op == OP_RD_START && r_k == 3'd0 && mem_rdata != SYNC_BYTE) begin
                    n_state = S_FIN;
                end else if (r_op == OP_RD_FINISH && mem_rdata != r_rs) begin
                    n_state = S_FIN;
                end else begin
                    n_state = step.last ? S_FIN : S_LOAD;
                end
            end
            S_FIN: n_state = out_load ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        mem_we     = (r_state == S_ACT) && (step.act == A_WR);
        mem_addr   = AW'(r_rem);
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    frpb_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (step.wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ring_size <= RING_SIZE_RST;
            r_csum_en   <= 1'b1;
            r_wp        <= '0;
            r_np        <= '0;
            r_rp        <= '0;
            r_writing   <= 1'b0;
            r_reading   <= 1'b0;
            r_wc        <= '0;
            r_rt        <= '0;
            r_rc        <= '0;
            r_ws        <= '0;
            r_rs        <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RING_SIZE) begin
                    r_ring_size <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_CSUM_EN) begin
                    r_csum_en <= i_cfg_wdata[0];
                end
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (in_op)
                            OP_WR_START: begin
                                r_writing <= 1'b1;
                                r_wc      <= '0;
                                r_ws      <= '0;
                            end
                            OP_RD_START: begin
                                if (r_wp != r_rp && i_s_tdata[11]) begin
                                    r_rp <= r_np;
                                end
                            end
                            OP_RD_FINISH: begin
                                if (r_reading) begin
                                    r_reading <= 1'b0;
                                    if (r_rc != r_rt) begin
                                        r_rp <= r_wp;
                                    end
                                end
                            end
                            OP_RD_ABORT: begin
                                r_reading <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ACT: begin
                    if (step.act == A_WR && r_op == OP_WR_BYTE) begin
                        r_wc <= r_wc + 32'd1;
                        r_ws <= r_ws + r_din;
                    end
                    if (step.act == A_PTR) begin
                        if (r_op == OP_WR_COMMIT) begin
                            r_np      <= r_wp;
                            r_wp      <= AW'(r_rem);
                            r_writing <= 1'b0;
                        end else begin
                            r_rp <= AW'(r_rem);
                        end
                    end
                end
                S_RDW: begin
                    if (r_op == OP_RD_START) begin
                        if (r_k == 3'd0 && mem_rdata != SYNC_BYTE) begin
                            r_rp <= r_wp;
                        end else if (step.last) begin
                            r_rt      <= {mem_rdata, r_lout[31:8]};
                            r_rc      <= '0;
                            r_rs      <= '0;
                            r_reading <= 1'b1;
                        end
                    end else if (r_op == OP_RD_BYTE) begin
                        r_rs <= r_rs + mem_rdata;
                        r_rc <= r_rc + 32'd1;
                    end else if (mem_rdata != r_rs) begin
                        r_rp <= r_wp;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_op     <= in_op;
                    r_din    <= i_s_tdata[10:3];
                    r_k      <= '0;
                    r_status <= ST_OK;
                    r_dout   <= '0;
                    r_lout   <= '0;
                    case (in_op)
                        OP_WR_START: begin
                        end
                        OP_WR_BYTE: begin
                            if (!r_writing) begin
                                r_status <= ST_NOT_OPEN;
                            end
                        end
                        OP_WR_COMMIT: begin
                            if (!r_writing) begin
                                r_status <= ST_NOT_OPEN;
                            end else begin
                                r_lout <= r_wc;
                            end
                        end
                        OP_RD_START: begin
                            if (r_wp == r_rp) begin
                                r_status <= ST_EMPTY;
                            end
                        end
                        OP_RD_BYTE: begin
                            if (!r_reading) begin
                                r_status <= ST_NOT_OPEN;
                            end else if (r_rc == r_rt) begin
                                r_status <= ST_EXHAUSTED;
                                r_lout   <= r_rc;
                            end
                        end
                        OP_RD_FINISH: begin
                            if (!r_reading) begin
                                r_status <= ST_NOT_OPEN;
                            end else begin
                                r_lout <= r_rc;
                                if (r_rc != r_rt) begin
                                    r_status <= ST_INCOMPLETE;
                                end else if (!r_csum_en) begin
                                    r_k <= 3'd1;
                                end
                            end
                        end
                        OP_RD_ABORT: begin
                            if (!r_reading) begin
                                r_status <= ST_NOT_OPEN;
                            end else begin
                                r_lout <= r_rc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                r_rem <= '0;
                r_dvd <= SUM_W'(step.use_rp ? r_rp : r_wp) + step.off;
                r_cnt <= '0;
            end
            S_CALC: begin
                r_rem <= (rem_try >= {1'b0, size_n}) ? rem_sub[NW-1:0] : rem_try[NW-1:0];
                r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_ACT: begin
                if (step.act == A_WR && r_op == OP_WR_BYTE) begin
                    r_lout <= r_wc + 32'd1;
                end
                if (step.act != A_RD) begin
                    r_k <= step.nk;
                end
            end
            S_RDW: begin
                r_k <= step.nk;
                if (r_op == OP_RD_START) begin
                    if (r_k == 3'd0) begin
                        if (mem_rdata != SYNC_BYTE) begin
                            r_status <= ST_BAD_SYNC;
                        end
                    end else begin
                        r_lout <= {mem_rdata, r_lout[31:8]};
                    end
                end else if (r_op == OP_RD_BYTE) begin
                    r_dout <= mem_rdata;
                    r_lout <= r_rc + 32'd1;
                end else if (mem_rdata != r_rs) begin
                    r_status <= ST_CSUM_ERR;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    r_m_data <= OUT_TDATA_W'({r_lout, r_dout, r_status});
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// ----- hw/rtl/frpb_ram.sv -----
// Single-port synchronous RAM with registered read.
module frpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- hw/rtl/frpb_checker.sv -----
// Port-level assertions for the framed packet ring buffer, bound to the top level.
module frpb_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [frpb_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [frpb_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import frpb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("transfer taken while an operation is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:0] != 3'd7)
        else $error("undefined status code");

    a_no_data_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != ST_OK |-> o_m_tdata[10:3] == 8'd0)
        else $error("data byte returned with a failing status");
endmodule

bind framed_packet_ring_buffer_unit frpb_checker u_frpb_checker (.*);
